### hw/rtl/htd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package htd_pkg;

   // default number of rotation stages
   localparam int CORDIC_STAGES_DEF = 16;

   // rotation datapath width (Q2.30 plus headroom)
   localparam int CW = 34;

   // gain-corrected start vector and quarter turn, Q2.30
   localparam logic [31:0] GAIN_Q30    = 32'd652032874;
   localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

   // saturated result
   localparam logic [31:0] DIST_MAX = 32'hFFFF_FFFF;

   // divisor width and quotient width
   localparam int DW = 38;
   localparam int QW = 32;

   // arctangent of 2^-i, Q2.30
   function automatic logic [31:0] atan_q30(input int unsigned i);
      logic [31:0] r;
      case (i)
         0:  r = 32'd843314856;
         1:  r = 32'd497837829;
         2:  r = 32'd263043836;
         3:  r = 32'd133525158;
         4:  r = 32'd67021686;
         5:  r = 32'd33543515;
         6:  r = 32'd16775850;
         7:  r = 32'd8388437;
         8:  r = 32'd4194282;
         9:  r = 32'd2097149;
         10: r = 32'd1048575;
         11: r = 32'd524287;
         12: r = 32'd262143;
         13: r = 32'd131071;
         14: r = 32'd65535;
         15: r = 32'd32767;
         16: r = 32'd16383;
         17: r = 32'd8191;
         18: r = 32'd4095;
         19: r = 32'd2047;
         20: r = 32'd1023;
         21: r = 32'd511;
         22: r = 32'd255;
         23: r = 32'd127;
         24: r = 32'd63;
         25: r = 32'd31;
         26: r = 32'd15;
         27: r = 32'd8;
         28: r = 32'd4;
         29: r = 32'd2;
         30: r = 32'd1;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

### hw/rtl/htd_delay.sv
`timescale 1ns / 1ps
`default_nettype none
module htd_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  wire logic             clock,
   input  wire logic             en,
   input  wire logic [WIDTH-1:0] din,
   output logic      [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] tap_ff [DEPTH];

   // shift line, advances with the pipeline
   always_ff @(posedge clock) begin
      if (en) begin
         tap_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   assign dout = tap_ff[DEPTH-1];

endmodule
`default_nettype wire

### hw/rtl/htd_mul.sv
`timescale 1ns / 1ps
`default_nettype none
module htd_mul #(
   parameter int WA = 32,
   parameter int WB = 32
) (
   input  wire logic             clock,
   input  wire logic             en,
   input  wire logic [WA-1:0]    a,
   input  wire logic [WB-1:0]    b,
   output logic      [WA+WB-1:0] p
);

   localparam int LO = WB / 2;
   localparam int HI = WB - LO;

   logic [WA+LO-1:0] lo_ff, lo_in;
   logic [WA+HI-1:0] hi_ff, hi_in;

   // two partial products on the halves of b
   assign lo_in = (WA+LO)'(a) * (WA+LO)'(b[LO-1:0]);
   assign hi_in = (WA+HI)'(a) * (WA+HI)'(b[WB-1:LO]);

   always_ff @(posedge clock) begin
      if (en) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
         p     <= (WA+WB)'(lo_ff) + ((WA+WB)'(hi_ff) << LO);
      end
   end

endmodule
`default_nettype wire

### hw/rtl/htd_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
module htd_cordic import htd_pkg::*; #(
   parameter int STAGES = CORDIC_STAGES_DEF
) (
   input  wire logic               clock,
   input  wire logic               en,
   input  wire logic [30:0]        theta,
   input  wire logic [1:0]         quad,
   output logic      signed [31:0] cos_out,
   output logic      signed [31:0] sin_out
);

   typedef enum logic [1:0] {QUAD_I, QUAD_II, QUAD_III, QUAD_IV} quad_type;

   logic signed [CW-1:0] x_ff [STAGES];
   logic signed [CW-1:0] y_ff [STAGES];
   logic signed [CW-1:0] z_ff [STAGES];
   logic        [1:0]    q_ff [STAGES];

   // one micro-rotation per stage
   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      logic signed [CW-1:0] xi, yi, zi, dx, dy, at;
      logic        [1:0]    qi;
      if (i == 0) begin : g_first
         assign xi = CW'(GAIN_Q30);
         assign yi = '0;
         assign zi = signed'({3'b000, theta});
         assign qi = quad;
      end else begin : g_next
         assign xi = x_ff[i-1];
         assign yi = y_ff[i-1];
         assign zi = z_ff[i-1];
         assign qi = q_ff[i-1];
      end
      assign dx = yi >>> i;
      assign dy = xi >>> i;
      assign at = signed'({2'b00, atan_q30(i)});
      always_ff @(posedge clock) begin
         if (en) begin
            q_ff[i] <= qi;
            if (!zi[CW-1]) begin
               x_ff[i] <= xi - dx;
               y_ff[i] <= yi + dy;
               z_ff[i] <= zi - at;
            end else begin
               x_ff[i] <= xi + dx;
               y_ff[i] <= yi - dy;
               z_ff[i] <= zi + at;
            end
         end
      end
   end

   logic signed [CW-1:0] xl, yl, cos_in, sin_in;
   assign xl = x_ff[STAGES-1];
   assign yl = y_ff[STAGES-1];

   // quadrant fold
   always_comb begin
      unique case (quad_type'(q_ff[STAGES-1]))
         QUAD_I:   begin cos_in = xl;  sin_in = yl;  end
         QUAD_II:  begin cos_in = -yl; sin_in = xl;  end
         QUAD_III: begin cos_in = -xl; sin_in = -yl; end
         QUAD_IV:  begin cos_in = yl;  sin_in = -xl; end
         default:  begin cos_in = xl;  sin_in = yl;  end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cos_out <= cos_in[31:0];
         sin_out <= sin_in[31:0];
      end
   end

endmodule
`default_nettype wire

### hw/rtl/htd_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
module htd_sqrt (
   input  wire logic        clock,
   input  wire logic        en,
   input  wire logic [63:0] rad,
   output logic      [31:0] root
);

   logic [63:0] rad_ff  [32];
   logic [33:0] rem_ff  [32];
   logic [31:0] root_ff [32];

   // one root bit per stage, two radicand bits in
   for (genvar i = 0; i < 32; i++) begin : g_stage
      logic [63:0] radi;
      logic [33:0] remi;
      logic [31:0] rooti;
      logic [35:0] r2, trial;
      logic        ge;
      if (i == 0) begin : g_first
         assign radi  = rad;
         assign remi  = '0;
         assign rooti = '0;
      end else begin : g_next
         assign radi  = rad_ff[i-1];
         assign remi  = rem_ff[i-1];
         assign rooti = root_ff[i-1];
      end
      assign r2    = {remi, radi[63:62]};
      assign trial = {2'b00, rooti, 2'b01};
      assign ge    = (r2 >= trial);
      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[i]  <= {radi[61:0], 2'b00};
            rem_ff[i]  <= ge ? 34'(r2 - trial) : r2[33:0];
            root_ff[i] <= {rooti[30:0], ge};
         end
      end
   end

   assign root = root_ff[31];

endmodule
`default_nettype wire

### hw/rtl/htd_div.sv
`timescale 1ns / 1ps
`default_nettype none
module htd_div import htd_pkg::*; (
   input  wire logic          clock,
   input  wire logic          en,
   input  wire logic [DW-1:0] rem0,
   input  wire logic [QW-1:0] lo,
   input  wire logic [DW-1:0] dvs,
   output logic      [QW-1:0] quot
);

   logic [DW-1:0] rem_ff [QW];
   logic [QW-1:0] lo_ff  [QW];
   logic [DW-1:0] d_ff   [QW];
   logic [QW-1:0] q_ff   [QW];

   // restoring division, one quotient bit per stage
   for (genvar i = 0; i < QW; i++) begin : g_stage
      logic [DW-1:0] remi, di;
      logic [QW-1:0] loi, qi;
      logic [DW:0]   r2;
      logic          ge;
      if (i == 0) begin : g_first
         assign remi = rem0;
         assign loi  = lo;
         assign di   = dvs;
         assign qi   = '0;
      end else begin : g_next
         assign remi = rem_ff[i-1];
         assign loi  = lo_ff[i-1];
         assign di   = d_ff[i-1];
         assign qi   = q_ff[i-1];
      end
      assign r2 = {remi, loi[QW-1]};
      assign ge = (r2 >= {1'b0, di});
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i] <= ge ? DW'(r2 - {1'b0, di}) : r2[DW-1:0];
            lo_ff[i]  <= {loi[QW-2:0], 1'b0};
            d_ff[i]   <= di;
            q_ff[i]   <= {qi[QW-2:0], ge};
         end
      end
   end

   assign quot = q_ff[QW-1];

endmodule
`default_nettype wire

### hw/rtl/hit_track_distance.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   | direction | contents
// req_      | in        | hit and track: tuser op, tdata coordinates and track
// rsp_      | out       | tuser used_circle, tdata distance
// csr_      | in        | curvature threshold write
//
// One request per cycle while the response is not stalled; the latency is set by
// the rotation stages, the 32-stage square root and the 32-stage divider.
// Synchronous reset clears the valid bits and the threshold.
// A stalled response freezes every stage; requests are taken whenever the
// output register is empty or being read.
module hit_track_distance import htd_pkg::*; #(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // hit_x, hit_y, hit_s, hit_z, track_angle, impact_offset, curvature,
   // dip_slope, z_offset
   input  wire logic [271:0] req_tdata,
   // op
   input  wire logic [0:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // distance
   output logic      [31:0]  rsp_tdata,
   // used_circle
   output logic      [0:0]   rsp_tuser,
   input  wire logic         csr_we,
   input  wire logic [30:0]  csr_wdata
);

   localparam int N       = CORDIC_STAGES;
   localparam int VLD_LEN = N + 79;

   logic en;
   logic [VLD_LEN-1:0] vld_ff;
   logic [30:0] thr_ff;

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[VLD_LEN-1];

   // valid bits and threshold
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         thr_ff <= '0;
      end else begin
         if (en) vld_ff <= {vld_ff[VLD_LEN-2:0], req_tvalid};
         if (csr_we) thr_ff <= csr_wdata;
      end
   end

   // request fields
   logic signed [31:0] f_x, f_y, f_s, f_z, f_d0, f_om, f_t, f_z0;
   logic        [15:0] f_ang;
   assign f_x   = req_tdata[31:0];
   assign f_y   = req_tdata[63:32];
   assign f_s   = req_tdata[95:64];
   assign f_z   = req_tdata[127:96];
   assign f_ang = req_tdata[143:128];
   assign f_d0  = req_tdata[175:144];
   assign f_om  = req_tdata[207:176];
   assign f_t   = req_tdata[239:208];
   assign f_z0  = req_tdata[271:240];

   // input stage
   logic signed [31:0] x0_ff, y0_ff, s0_ff, hz0_ff, d00_ff, t0_ff, zo0_ff;
   logic        [31:0] w0_ff, w0_in;
   logic        [30:0] theta0_ff, theta0_in;
   logic        [1:0]  quad0_ff;
   logic               op0_ff, neg0_ff, circ0_ff, circ0_in;

   assign w0_in     = f_om[31] ? 32'(32'd0 - f_om) : f_om;
   assign circ0_in  = !req_tuser[0] && (32'(thr_ff) < w0_in);
   assign theta0_in = 31'((45'(f_ang[13:0]) * 45'(HALF_PI_Q30)) >> 14);

   always_ff @(posedge clock) begin
      if (en) begin
         x0_ff     <= f_x;
         y0_ff     <= f_y;
         s0_ff     <= f_s;
         hz0_ff    <= f_z;
         d00_ff    <= f_d0;
         t0_ff     <= f_t;
         zo0_ff    <= f_z0;
         w0_ff     <= w0_in;
         neg0_ff   <= f_om[31];
         theta0_ff <= theta0_in;
         quad0_ff  <= f_ang[15:14];
         op0_ff    <= req_tuser[0];
         circ0_ff  <= circ0_in;
      end
   end

   // s-z numerator and radicand
   logic signed [63:0] tt1_ff, ts1_ff;
   logic signed [32:0] dz1_ff;
   logic signed [64:0] num_w;
   logic        [63:0] absnum2_ff, radsz2_ff;

   assign num_w = (65'(dz1_ff) <<< 16) - 65'(ts1_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         tt1_ff     <= 64'(t0_ff) * 64'(t0_ff);
         ts1_ff     <= 64'(t0_ff) * 64'(s0_ff);
         dz1_ff     <= 33'(hz0_ff) - 33'(zo0_ff);
         absnum2_ff <= num_w[64] ? 64'(-num_w) : 64'(num_w);
         radsz2_ff  <= 64'h1_0000_0000 + 64'(tt1_ff);
      end
   end

   logic [63:0] absnum10, radsz10;
   htd_delay #(.WIDTH(128), .DEPTH(N + 8)) u_dly_sz (
      .clock(clock), .en(en),
      .din({absnum2_ff, radsz2_ff}), .dout({absnum10, radsz10})
   );

   logic [1:0] tag10;
   htd_delay #(.WIDTH(2), .DEPTH(N + 10)) u_dly_tag (
      .clock(clock), .en(en),
      .din({op0_ff, circ0_ff}), .dout(tag10)
   );

   // sine and cosine of the track angle
   logic signed [31:0] cs1, sn1;
   htd_cordic #(.STAGES(N)) u_cordic (
      .clock(clock), .en(en), .theta(theta0_ff), .quad(quad0_ff),
      .cos_out(cs1), .sin_out(sn1)
   );

   logic signed [31:0] x1, y1, d1;
   logic        [31:0] w1;
   logic               neg1;
   htd_delay #(.WIDTH(129), .DEPTH(N + 1)) u_dly_hit (
      .clock(clock), .en(en),
      .din({x0_ff, y0_ff, d00_ff, w0_ff, neg0_ff}),
      .dout({x1, y1, d1, w1, neg1})
   );

   // products with sine and cosine
   logic signed [63:0] xs_ff, yc_ff, ds_ff, dc_ff;
   logic signed [31:0] xm_ff, ym_ff, dm_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         xs_ff <= 64'(x1) * 64'(sn1);
         yc_ff <= 64'(y1) * 64'(cs1);
         ds_ff <= 64'(d1) * 64'(sn1);
         dc_ff <= 64'(d1) * 64'(cs1);
         xm_ff <= x1;
         ym_ff <= y1;
         dm_ff <= d1;
      end
   end

   // signed line distance and circle offset point
   logic signed [65:0] v_ff;
   logic signed [33:0] px_ff, py_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         v_ff  <= 66'(yc_ff) - 66'(xs_ff) - (66'(dm_ff) <<< 30);
         px_ff <= 34'(xm_ff) + 34'(ds_ff >>> 30);
         py_ff <= 34'(ym_ff) - 34'(dc_ff >>> 30);
      end
   end

   // rounding and squares
   logic        [65:0] absv;
   logic        [35:0] em;
   logic signed [36:0] e4_ff;
   logic        [31:0] line4_ff;
   logic signed [67:0] px2_ff, py2_ff;
   assign absv = v_ff[65] ? 66'(-v_ff) : 66'(v_ff);
   assign em   = 36'((absv + 66'(1 << 29)) >> 30);
   always_ff @(posedge clock) begin
      if (en) begin
         e4_ff    <= v_ff[65] ? -signed'({1'b0, em}) : signed'({1'b0, em});
         line4_ff <= (|em[35:32]) ? DIST_MAX : em[31:0];
         px2_ff   <= 68'(px_ff) * 68'(px_ff);
         py2_ff   <= 68'(py_ff) * 68'(py_ff);
      end
   end

   // sum of squares
   logic [49:0] p5_ff;
   always_ff @(posedge clock) begin
      if (en) p5_ff <= 50'(px2_ff[67:16]) + 50'(py2_ff[67:16]);
   end

   logic [31:0] w5, w7;
   logic        neg5, neg7;
   htd_delay #(.WIDTH(33), .DEPTH(4)) u_dly_w5 (
      .clock(clock), .en(en), .din({w1, neg1}), .dout({w5, neg5})
   );
   htd_delay #(.WIDTH(33), .DEPTH(2)) u_dly_w7 (
      .clock(clock), .en(en), .din({w5, neg5}), .dout({w7, neg7})
   );

   logic signed [36:0] e7;
   htd_delay #(.WIDTH(37), .DEPTH(3)) u_dly_e (
      .clock(clock), .en(en), .din(e4_ff), .dout(e7)
   );

   logic [31:0] line77;
   htd_delay #(.WIDTH(32), .DEPTH(73)) u_dly_line (
      .clock(clock), .en(en), .din(line4_ff), .dout(line77)
   );

   // curvature times sum of squares
   logic [81:0] prod1;
   htd_mul #(.WA(32), .WB(50)) u_mul_p (
      .clock(clock), .en(en), .a(w5), .b(p5_ff), .p(prod1)
   );

   // E term
   logic signed [53:0] e8_ff, e_in;
   logic signed [37:0] twoe;
   logic        [31:0] w8_ff;
   logic        [52:0] abse8;
   assign twoe = {e7, 1'b0};
   assign e_in = signed'(54'(prod1[81:30]))
               + (neg7 ? -(54'(twoe)) : 54'(twoe));
   always_ff @(posedge clock) begin
      if (en) begin
         e8_ff <= e_in;
         w8_ff <= w7;
      end
   end
   assign abse8 = e8_ff[53] ? 53'(-e8_ff) : 53'(e8_ff);

   // curvature times |E|
   logic [84:0] prod2;
   htd_mul #(.WA(32), .WB(53)) u_mul_q (
      .clock(clock), .en(en), .a(w8_ff), .b(abse8), .p(prod2)
   );

   logic signed [53:0] e10;
   htd_delay #(.WIDTH(54), .DEPTH(2)) u_dly_e10 (
      .clock(clock), .en(en), .din(e8_ff), .dout(e10)
   );

   // radicand select
   logic        [54:0] qm;
   logic signed [56:0] u_w;
   logic        [52:0] abse10;
   logic        [63:0] rad11_ff;
   logic        [68:0] nume11_ff;
   logic               big_w, big11_ff, op11_ff, circ11_ff;
   assign qm     = prod2[84:30];
   assign u_w    = 57'sd65536 + (e10[53] ? -signed'({2'b00, qm}) : signed'({2'b00, qm}));
   assign big_w  = !u_w[56] && (u_w[55:47] != '0);
   assign abse10 = e10[53] ? 53'(-e10) : 53'(e10);
   always_ff @(posedge clock) begin
      if (en) begin
         if (tag10[1])      rad11_ff <= radsz10;
         else if (u_w[56])  rad11_ff <= '0;
         else if (big_w)    rad11_ff <= 64'(u_w[55:0]);
         else               rad11_ff <= {u_w[47:0], 16'h0000};
         nume11_ff <= tag10[1] ? 69'(absnum10) : {abse10, 16'h0000};
         big11_ff  <= big_w;
         op11_ff   <= tag10[1];
         circ11_ff <= tag10[0];
      end
   end

   logic [31:0] root43;
   htd_sqrt u_sqrt (
      .clock(clock), .en(en), .rad(rad11_ff), .root(root43)
   );

   logic [68:0] nume43;
   logic        big43, op43, circ43;
   htd_delay #(.WIDTH(72), .DEPTH(32)) u_dly_sq (
      .clock(clock), .en(en),
      .din({nume11_ff, big11_ff, op11_ff, circ11_ff}),
      .dout({nume43, big43, op43, circ43})
   );

   // divisor
   logic [DW-1:0] d44_ff;
   logic [68:0]   nume44_ff;
   logic          op44_ff, circ44_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         if (op43)       d44_ff <= DW'(root43);
         else if (big43) d44_ff <= DW'(65536) + (DW'(root43) << 8);
         else            d44_ff <= DW'(65536) + DW'(root43);
         nume44_ff <= nume43;
         op44_ff   <= op43;
         circ44_ff <= circ43;
      end
   end

   // rounding bias and overflow check
   logic [69:0]   tot;
   logic [DW-1:0] hi_w;
   logic [DW-1:0] h45_ff, d45_ff;
   logic [QW-1:0] lo45_ff;
   logic          sat45_ff, op45_ff, circ45_ff;
   assign tot  = 70'(nume44_ff) + 70'(d44_ff >> 1);
   assign hi_w = tot[69:32];
   always_ff @(posedge clock) begin
      if (en) begin
         h45_ff    <= hi_w;
         lo45_ff   <= tot[31:0];
         d45_ff    <= d44_ff;
         sat45_ff  <= (hi_w >= d44_ff);
         op45_ff   <= op44_ff;
         circ45_ff <= circ44_ff;
      end
   end

   logic [QW-1:0] quot77;
   htd_div u_div (
      .clock(clock), .en(en), .rem0(h45_ff), .lo(lo45_ff), .dvs(d45_ff),
      .quot(quot77)
   );

   logic sat77, op77, circ77;
   htd_delay #(.WIDTH(3), .DEPTH(32)) u_dly_dv (
      .clock(clock), .en(en),
      .din({sat45_ff, op45_ff, circ45_ff}), .dout({sat77, op77, circ77})
   );

   // output register
   always_ff @(posedge clock) begin
      if (en) begin
         if (op77 || circ77) rsp_tdata <= sat77 ? DIST_MAX : quot77;
         else                rsp_tdata <= line77;
         rsp_tuser <= circ77;
      end
   end

endmodule
`default_nettype wire
